[design/gifc_pkg.sv]
// ----------------------------------------------------------------------------
// gifc_pkg
// Shared types and constants for the GIF line palette compositor.
// ----------------------------------------------------------------------------
package gifc_pkg;

  localparam int ColorW          = 24;
  localparam int AddrW           = 16;
  localparam int CountW          = 9;
  localparam int PaletteDepthDef = 256;
  localparam int MaxCanvasWidth  = 256;  // canvas width saturates here; the 9-bit register holds at most 511
  localparam int CanvasWidthRst  = 64;

  // input request layout in s_axis_tdata
  localparam int InDataW = 80;
  localparam int OutDataW = 40;

  typedef enum logic [1:0] {
    OpLoadLine   = 2'd0,
    OpLoadGlobal = 2'd1,
    OpHeader     = 2'd2,
    OpPixel      = 2'd3
  } gifc_op_e;

  typedef enum logic [0:0] {
    CfgTranspMode  = 1'b0,
    CfgCanvasWidth = 1'b1
  } gifc_cfg_e;

  typedef enum logic [1:0] {
    TrHonor = 2'd0,
    TrMatch = 2'd1,
    TrAny   = 2'd2
  } gifc_tr_mode_e;

endpackage

[design/gifc_palette_ram.sv]
// ----------------------------------------------------------------------------
// gifc_palette_ram
// Single write port, single read port palette store, registered read data.
// ----------------------------------------------------------------------------
module gifc_palette_ram #(
  parameter int Depth = 256,
  parameter int Width = 24,
  localparam int Aw = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/gif_line_palette_compositor.sv]
// ----------------------------------------------------------------------------
// gif_line_palette_compositor
// Palette index to RGB frame-buffer write conversion for GIF lines.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake                  Payload
// s_axis   in   s_axis_tvalid/tready       tuser opcode, tdata load/header/pixel
// m_axis   out  m_axis_tvalid/tready       tuser write_enable, tdata addr+rgb,
//                                          tlast line_end
// cfg      in   cfg_valid_i/cfg_ready_o    cfg_index_i, cfg_data_i
//
// One request per cycle sustained while the output is not blocked. A pixel's
// palette read is registered with its request, the output register next.
// Reset: palettes are not cleared; no clearing pass, ready right after reset.
// s_axis_tready drops only while a pixel waits in the read stage and the
// output register holds a result not yet taken.
// cfg_ready_o is always high.
// ----------------------------------------------------------------------------
module gif_line_palette_compositor #(
  parameter int PALETTE_DEPTH = gifc_pkg::PaletteDepthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // tdata: entry_index[7:0], entry_color[31:8], has_transparency[32],
  //   transparent_index[40:33], restore_background[41], has_global_palette[42],
  //   background_index[50:43], row[58:51], column[66:59], line_width[75:67]
  input  logic [gifc_pkg::InDataW-1:0]  s_axis_tdata,
  // tuser: opcode[1:0]
  input  logic [1:0]                    s_axis_tuser,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // tdata: write_address[15:0], red[23:16], green[31:24], blue[39:32]
  output logic [gifc_pkg::OutDataW-1:0] m_axis_tdata,
  // tuser: write_enable[0]
  output logic                          m_axis_tuser,
  output logic                          m_axis_tlast,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [0:0]                    cfg_index_i,
  input  logic [8:0]                    cfg_data_i
);

  import gifc_pkg::*;

  localparam int PalAw = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

  // request fields
  gifc_op_e            in_op;
  logic [7:0]          in_idx;
  logic [ColorW-1:0]   in_color;
  logic                in_has_tr;
  logic [7:0]          in_tr_key;
  logic                in_restore;
  logic                in_has_gp;
  logic [7:0]          in_bg_idx;
  logic [7:0]          in_row;
  logic [7:0]          in_col;
  logic [CountW-1:0]   in_width;

  assign in_op      = gifc_op_e'(s_axis_tuser);
  assign in_idx     = s_axis_tdata[7:0];
  assign in_color   = s_axis_tdata[31:8];
  assign in_has_tr  = s_axis_tdata[32];
  assign in_tr_key  = s_axis_tdata[40:33];
  assign in_restore = s_axis_tdata[41];
  assign in_has_gp  = s_axis_tdata[42];
  assign in_bg_idx  = s_axis_tdata[50:43];
  assign in_row     = s_axis_tdata[58:51];
  assign in_col     = s_axis_tdata[66:59];
  assign in_width   = s_axis_tdata[75:67];

  // config registers
  logic [1:0]        tr_mode_q;
  logic [8:0]        canvas_width_q;

  // line and frame state
  logic              first_frame_q;
  logic              bg_valid_q;
  logic [ColorW-1:0] bg_rgb_q;
  logic              line_tr_on_q;
  logic [7:0]        line_tr_key_q;
  logic              line_restore_q;
  logic [AddrW-1:0]  line_base_q;
  logic [CountW-1:0] line_length_q;
  logic [CountW-1:0] pixel_count_q;

  // read stage
  logic              p1_pix_q;
  logic              p1_bg_q;
  logic              p1_bg_black_q;
  logic              p1_oor_q;
  logic              p1_sel_line_q;
  logic              p1_sel_bg_q;
  logic [AddrW-1:0]  p1_addr_q;
  logic              p1_last_q;

  // output register
  logic              out_valid_q;
  logic [AddrW-1:0]  out_addr_q;
  logic [ColorW-1:0] out_rgb_q;
  logic              out_we_q;
  logic              out_last_q;

  logic              adv;
  logic              accept;
  logic              idx_oor;
  logic              bg_oor;
  logic              in_line;
  logic              is_tr;
  logic              hdr_bg;
  logic              bg_black;
  logic [8:0]        cw_eff;
  logic [16:0]       row_prod;
  logic [AddrW-1:0]  base_next;
  logic [CountW-1:0] pc_inc;
  logic [ColorW-1:0] line_rd;
  logic [ColorW-1:0] glob_rd;

  assign adv           = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !(p1_pix_q && !adv);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  assign idx_oor = {1'b0, in_idx} >= 9'(PALETTE_DEPTH);
  assign bg_oor  = {1'b0, in_bg_idx} >= 9'(PALETTE_DEPTH);

  // pixel decisions
  assign pc_inc  = pixel_count_q + 1'b1;
  assign in_line = pixel_count_q < line_length_q;
  assign is_tr   = line_tr_on_q && (in_idx == line_tr_key_q);

  // header geometry
  assign cw_eff    = ({2'b00, canvas_width_q} > 11'(MaxCanvasWidth)) ?
                     9'(MaxCanvasWidth) : canvas_width_q;
  assign row_prod  = {9'd0, in_row} * {8'd0, cw_eff};
  assign base_next = row_prod[AddrW-1:0] + {8'd0, in_col};

  assign hdr_bg = first_frame_q && in_has_gp;

  always_comb begin
    unique case (tr_mode_q)
      TrMatch: bg_black = in_has_tr && (in_tr_key == in_bg_idx);
      TrAny:   bg_black = in_has_tr;
      default: bg_black = 1'b0;
    endcase
  end

  gifc_palette_ram #(
    .Depth (PALETTE_DEPTH),
    .Width (ColorW)
  ) u_line_pal (
    .clk_i   (clk_i),
    .we_i    (accept && in_op == OpLoadLine && !idx_oor),
    .waddr_i (in_idx[PalAw-1:0]),
    .wdata_i (in_color),
    .re_i    (accept && in_op == OpPixel),
    .raddr_i (in_idx[PalAw-1:0]),
    .rdata_o (line_rd)
  );

  gifc_palette_ram #(
    .Depth (PALETTE_DEPTH),
    .Width (ColorW)
  ) u_global_pal (
    .clk_i   (clk_i),
    .we_i    (accept && in_op == OpLoadGlobal && !idx_oor),
    .waddr_i (in_idx[PalAw-1:0]),
    .wdata_i (in_color),
    .re_i    (accept && in_op == OpHeader && hdr_bg),
    .raddr_i (in_bg_idx[PalAw-1:0]),
    .rdata_o (glob_rd)
  );

  // config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tr_mode_q      <= TrHonor;
      canvas_width_q <= 9'(CanvasWidthRst);
    end else if (cfg_valid_i) begin
      unique case (gifc_cfg_e'(cfg_index_i))
        CfgTranspMode:  tr_mode_q      <= cfg_data_i[1:0];
        CfgCanvasWidth: canvas_width_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // request stage: scalar state and read-stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_frame_q  <= 1'b1;
      bg_valid_q     <= 1'b0;
      line_tr_on_q   <= 1'b0;
      line_tr_key_q  <= '0;
      line_restore_q <= 1'b0;
      line_base_q    <= '0;
      line_length_q  <= '0;
      pixel_count_q  <= '0;
      p1_pix_q       <= 1'b0;
      p1_bg_q        <= 1'b0;
    end else begin
      // background fetch drains every cycle, it drives no output
      p1_bg_q <= accept && in_op == OpHeader && hdr_bg;
      if (s_axis_tready) begin
        p1_pix_q <= accept && in_op == OpPixel;
      end
      if (accept && in_op == OpHeader) begin
        if (first_frame_q) begin
          first_frame_q <= 1'b0;
          bg_valid_q    <= in_has_gp;
        end
        line_tr_on_q   <= in_has_tr;
        line_tr_key_q  <= in_tr_key;
        line_restore_q <= in_restore;
        line_base_q    <= base_next;
        line_length_q  <= in_width;
        pixel_count_q  <= '0;
      end else if (accept && in_op == OpPixel && in_line) begin
        pixel_count_q <= pc_inc;
      end
    end
  end

  // read stage payload
  always_ff @(posedge clk_i) begin
    if (accept && in_op == OpPixel) begin
      p1_oor_q      <= idx_oor;
      p1_sel_line_q <= in_line && !is_tr;
      p1_sel_bg_q   <= in_line && is_tr && line_restore_q && bg_valid_q;
      p1_addr_q     <= in_line ? line_base_q + {7'd0, pixel_count_q} : '0;
      p1_last_q     <= in_line && (pc_inc == line_length_q);
    end
    if (accept && in_op == OpHeader) begin
      p1_bg_black_q <= bg_black || bg_oor;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bg_rgb_q <= '0;
    end else if (p1_bg_q) begin
      bg_rgb_q <= p1_bg_black_q ? '0 : glob_rd;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= p1_pix_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && p1_pix_q) begin
      out_addr_q <= p1_addr_q;
      out_we_q   <= p1_sel_line_q || p1_sel_bg_q;
      out_last_q <= p1_last_q;
      priority if (p1_sel_line_q) begin
        out_rgb_q <= p1_oor_q ? '0 : line_rd;
      end else if (p1_sel_bg_q) begin
        out_rgb_q <= bg_rgb_q;
      end else begin
        out_rgb_q <= '0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_rgb_q[7:0], out_rgb_q[15:8], out_rgb_q[23:16], out_addr_q};
  assign m_axis_tuser  = out_we_q;
  assign m_axis_tlast  = out_last_q;

`ifndef SYNTHESIS
  // request side stalls only behind a blocked result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (p1_pix_q && out_valid_q && !m_axis_tready))
    else $error("input stalled without a blocked result");

  // skipped pixels carry black
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[39:16] == '0))
    else $error("skip result with nonzero color");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pixel_count_q <= line_length_q)
    else $error("pixel count ran past line length");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_op == OpHeader) |=> !first_frame_q)
    else $error("first frame flag not cleared by header");
`endif

endmodule

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the GIF line palette compositor. A directed table
// of palette loads, line headers and pixels runs first. Random lines follow
// under four register settings, with random stalls on both streams in the first
// two and one long output stall. Every pixel write is predicted and compared
// field by field, in order.
// ----------------------------------------------------------------------------
module tb_top;
  import gifc_pkg::*;

  localparam int         CycleLimit  = 400000;
  localparam int         DrainCycles = 4;
  localparam int         PhaseItems  = 320;
  localparam int         HoldCycles  = 300;
  localparam int         MaxReports  = 10;
  localparam logic [1:0] TrReserved  = 2'd3;  // unused mode code, acts as honor

  localparam int         SendIdle  [4] = '{26, 74, 0, 0};
  localparam int         RecvIdle  [4] = '{74, 26, 0, 0};
  localparam logic [1:0] PhaseMode [4] = '{TrHonor, TrAny, TrReserved, TrMatch};
  localparam logic [8:0] PhaseCw   [4] = '{9'd1, 9'd511, 9'd0, 9'd0};

  typedef struct packed {
    logic        we;
    logic [15:0] addr;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        last;
  } fb_write_t;

  typedef struct packed {
    gifc_op_e    op;
    logic [7:0]  idx;
    logic [23:0] color;
    logic        has_tr;
    logic [7:0]  tr_key;
    logic        restore;
    logic        has_gp;
    logic [7:0]  bg_idx;
    logic [7:0]  row;
    logic [7:0]  col;
    logic [8:0]  width;
    logic        fixed;     // expected write typed in the table
    fb_write_t   fixed_wr;
  } gif_req_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic [1:0]          s_axis_tuser  = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tuser;
  logic                m_axis_tlast;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [0:0]          cfg_index_i   = '0;
  logic [8:0]          cfg_data_i    = '0;

  gif_req_t  cur_req = '0;
  fb_write_t pending_writes[$];
  int        mismatch_cnt  = 0;
  int        cycle_cnt     = 0;
  int        send_idle_pct = SendIdle[0];
  int        recv_idle_pct = RecvIdle[0];
  int        recv_hold     = 0;

  // predictor state
  logic [23:0] line_pal [256];
  logic [23:0] glob_pal [256];
  bit          first_hdr  = 1'b1;
  bit          bg_valid   = 1'b0;
  bit          bg_black   = 1'b0;
  logic [23:0] bg_rgb     = '0;
  bit          ln_tr_on   = 1'b0;
  logic [7:0]  ln_tr_key  = '0;
  bit          ln_restore = 1'b0;
  logic [15:0] ln_base    = '0;
  logic [8:0]  ln_len     = '0;
  logic [8:0]  ln_cnt     = '0;
  logic [1:0]  cfg_mode   = TrHonor;
  logic [8:0]  cfg_cw     = 9'(CanvasWidthRst);

  // entries already loaded, so pixels never read an unwritten one
  bit line_loaded [256];
  bit glob_loaded [256];

  gif_line_palette_compositor DUT (.*);

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("FAIL gif_line_palette_compositor");
      $finish;
    end
  end

  function automatic void composite_step(input gif_req_t r, output bit produced,
                                         output fb_write_t wr);
    int cw;
    produced = 1'b0;
    wr       = '0;
    case (r.op)
      OpLoadLine:   line_pal[r.idx] = r.color;
      OpLoadGlobal: glob_pal[r.idx] = r.color;
      OpHeader: begin
        if (first_hdr) begin
          first_hdr = 1'b0;
          bg_valid  = r.has_gp;
          bg_black  = 1'b0;
          if (r.has_gp) begin
            if (cfg_mode == TrMatch) bg_black = r.has_tr && (r.tr_key == r.bg_idx);
            else if (cfg_mode == TrAny) bg_black = r.has_tr;
            bg_rgb = glob_pal[r.bg_idx];
          end
        end
        cw         = (cfg_cw > MaxCanvasWidth) ? MaxCanvasWidth : int'(cfg_cw);
        ln_tr_on   = r.has_tr;
        ln_tr_key  = r.tr_key;
        ln_restore = r.restore;
        ln_base    = 16'(int'(r.row) * cw + int'(r.col));
        ln_len     = r.width;
        ln_cnt     = '0;
      end
      default: begin
        produced = 1'b1;
        if (ln_cnt < ln_len) begin
          wr.addr = ln_base + 16'(ln_cnt);
          wr.last = (ln_cnt + 9'd1 == ln_len);
          if (ln_tr_on && r.idx == ln_tr_key) begin
            if (ln_restore && bg_valid) begin
              wr.we = 1'b1;
              {wr.red, wr.green, wr.blue} = bg_black ? 24'h0 : bg_rgb;
            end
          end else begin
            wr.we = 1'b1;
            {wr.red, wr.green, wr.blue} = line_pal[r.idx];
          end
          ln_cnt = ln_cnt + 9'd1;
        end
      end
    endcase
  endfunction

  function automatic void note_mismatch(string what, fb_write_t e, fb_write_t g);
    mismatch_cnt++;
    if (mismatch_cnt <= MaxReports)
      $display("%s: exp we=%0d addr=%h rgb=%h_%h_%h last=%0d, got we=%0d addr=%h rgb=%h_%h_%h last=%0d",
               what, e.we, e.addr, e.red, e.green, e.blue, e.last,
               g.we, g.addr, g.red, g.green, g.blue, g.last);
  endfunction

  // scoreboard: predict on request accept, compare on write accept
  always @(posedge clk_i) begin
    bit        produced;
    fb_write_t wr;
    fb_write_t got;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CfgTranspMode) cfg_mode = cfg_data_i[1:0];
        else cfg_cw = cfg_data_i;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        composite_step(cur_req, produced, wr);
        if (produced) pending_writes.push_back(cur_req.fixed ? cur_req.fixed_wr : wr);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[23:16],
                m_axis_tdata[31:24], m_axis_tdata[39:32], m_axis_tlast};
        if (pending_writes.size() == 0) begin
          note_mismatch("unexpected write", '0, got);
        end else begin
          wr = pending_writes.pop_front();
          if (wr !== got) note_mismatch("write mismatch", wr, got);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (recv_hold > 0) begin
      recv_hold = recv_hold - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(1, 100) > recv_idle_pct);
    end
  end

  function automatic gif_req_t plain(gifc_op_e op, logic [7:0] idx, logic [23:0] color);
    plain       = '0;
    plain.op    = op;
    plain.idx   = idx;
    plain.color = color;
  endfunction

  function automatic gif_req_t hdr(logic has_tr, logic [7:0] key, logic restore,
                                   logic has_gp, logic [7:0] bg, logic [7:0] row,
                                   logic [7:0] col, logic [8:0] width);
    hdr         = plain(OpHeader, 8'h00, 24'h0);
    hdr.has_tr  = has_tr;
    hdr.tr_key  = key;
    hdr.restore = restore;
    hdr.has_gp  = has_gp;
    hdr.bg_idx  = bg;
    hdr.row     = row;
    hdr.col     = col;
    hdr.width   = width;
  endfunction

  function automatic gif_req_t pix_at(logic [7:0] idx, logic we, logic [15:0] addr,
                                      logic [23:0] rgb, logic last);
    pix_at          = plain(OpPixel, idx, 24'h0);
    pix_at.fixed    = 1'b1;
    pix_at.fixed_wr = '{we, addr, rgb[23:16], rgb[15:8], rgb[7:0], last};
  endfunction

  function automatic logic [7:0] pick_line();
    logic [7:0] i;
    do i = 8'($urandom_range(0, 255)); while (!line_loaded[i]);
    return i;
  endfunction

  function automatic logic [7:0] pick_glob();
    logic [7:0] i;
    do i = 8'($urandom_range(0, 255)); while (!glob_loaded[i]);
    return i;
  endfunction

  function automatic logic [8:0] pick_width();
    int r;
    r = $urandom_range(0, 99);
    if (r < 2) return 9'd256;
    if (r < 10) return 9'd0;
    return 9'($urandom_range(1, 16));
  endfunction

  function automatic gif_req_t rand_req(gifc_op_e op);
    gif_req_t r;
    r          = '0;
    r.op       = op;
    r.idx      = 8'($urandom);
    r.color    = 24'($urandom);
    r.has_tr   = 1'($urandom);
    r.tr_key   = 8'($urandom);
    r.restore  = 1'($urandom);
    r.has_gp   = 1'($urandom);
    r.bg_idx   = 8'($urandom);
    r.row      = 8'($urandom);
    r.col      = 8'($urandom);
    r.width    = 9'($urandom);
    if (op == OpPixel) begin
      r.idx = pick_line();
    end else if (op == OpHeader) begin
      if (r.has_tr) r.tr_key = pick_line();
      r.bg_idx = pick_glob();
      r.width  = pick_width();
    end
    return r;
  endfunction

  task automatic issue(gif_req_t r);
    if (r.op == OpLoadLine) line_loaded[r.idx] = 1'b1;
    else if (r.op == OpLoadGlobal) glob_loaded[r.idx] = 1'b1;
    while (send_idle_pct > 0 && $urandom_range(1, 100) <= send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= r.op;
    s_axis_tdata  <= {4'b0, r.width, r.col, r.row, r.bg_idx, r.has_gp, r.restore,
                      r.tr_key, r.has_tr, r.color, r.idx};
    cur_req       <= r;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic set_regs(logic [1:0] mode, logic [8:0] cw);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CfgTranspMode;
    cfg_data_i  <= {7'b0, mode};
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_index_i <= CfgCanvasWidth;
    cfg_data_i  <= cw;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // loads and headers give no write, so allow for one still in flight
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_writes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic run_phase(int n_items);
    int       sent;
    int       sel;
    int       n_pix;
    gif_req_t h;
    gif_req_t p;
    sent = 0;
    while (sent < n_items) begin
      sel = $urandom_range(0, 99);
      if (sel < 15) begin
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 9) < 7) issue(rand_req(OpLoadLine));
          else issue(rand_req(OpLoadGlobal));
          sent++;
        end
      end else if (sel < 85) begin
        // header, its pixels, sometimes a few past the end of the line
        h = rand_req(OpHeader);
        issue(h);
        sent++;
        n_pix = int'(h.width) + (($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0);
        repeat (n_pix) begin
          p = rand_req(OpPixel);
          if (h.has_tr && $urandom_range(0, 9) < 3) p.idx = h.tr_key;
          issue(p);
          sent++;
        end
      end else begin
        issue(rand_req(gifc_op_e'($urandom_range(0, 3))));
        sent++;
      end
    end
  endtask

  initial begin
    gif_req_t   dir_tbl[$];
    logic [8:0] cw;
    dir_tbl = '{
      plain(OpLoadLine,   8'h00, 24'hFFFFFF),
      plain(OpLoadLine,   8'hFF, 24'h000000),
      plain(OpLoadLine,   8'h5A, 24'h123456),
      plain(OpLoadGlobal, 8'h00, 24'hA5A5A5),
      plain(OpLoadGlobal, 8'hFF, 24'h0F0F0F),
      pix_at(8'h00, 1'b0, 16'h0000, 24'h0, 1'b0),           // no header yet
      hdr(1'b1, 8'hFF, 1'b1, 1'b1, 8'hFF, 8'd0, 8'd0, 9'd4), // fixes background
      pix_at(8'h00, 1'b1, 16'h0000, 24'hFFFFFF, 1'b0),
      plain(OpPixel, 8'hFF, 24'h0),                         // black or bg per mode
      pix_at(8'h5A, 1'b1, 16'h0002, 24'h123456, 1'b0),
      plain(OpPixel, 8'hFF, 24'h0),
      pix_at(8'h00, 1'b0, 16'h0000, 24'h0, 1'b0),           // past line width
      hdr(1'b1, 8'h00, 1'b0, 1'b0, 8'h00, 8'd255, 8'd255, 9'd2),
      pix_at(8'h00, 1'b0, 16'hFFFF, 24'h0, 1'b0),           // transparent, kept
      pix_at(8'hFF, 1'b1, 16'h0000, 24'h000000, 1'b1),      // address wraps
      hdr(1'b0, 8'h5A, 1'b1, 1'b1, 8'h00, 8'd1, 8'd0, 9'd256),
      pix_at(8'h5A, 1'b1, 16'h0100, 24'h123456, 1'b0),
      hdr(1'b1, 8'h00, 1'b1, 1'b0, 8'h00, 8'd0, 8'd7, 9'd1),
      plain(OpPixel, 8'h00, 24'h0),                         // restored background
      hdr(1'b0, 8'h00, 1'b0, 1'b0, 8'h00, 8'd3, 8'd3, 9'd0),
      pix_at(8'hFF, 1'b0, 16'h0000, 24'h0, 1'b0)            // zero-width line
    };
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_regs(2'($urandom_range(0, 3)), 9'd256);
    foreach (dir_tbl[i]) issue(dir_tbl[i]);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = SendIdle[ph];
      recv_idle_pct = RecvIdle[ph];
      cw = (ph == 3) ? 9'($urandom_range(2, 255)) : PhaseCw[ph];
      set_regs(PhaseMode[ph], cw);
      if (ph == 2) recv_hold = HoldCycles;  // held output back-pressure, which stalls the input
      run_phase(PhaseItems);
      drain();
    end

    if (mismatch_cnt == 0) begin
      $display("PASS gif_line_palette_compositor");
    end else begin
      $display("FAIL gif_line_palette_compositor");
    end
    $finish;
  end

endmodule

[filelist.f]
design/gifc_pkg.sv
design/gifc_palette_ram.sv
design/gif_line_palette_compositor.sv
dv/tb_top.sv
